FILE: rtl/double_ended_queue_defines.svh
// Assertion macros shared by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define DEQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed: next-cycle implication");

`endif

FILE: rtl/deq_pkg.sv
// Package with types and constants for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int WORD_BITS_DEFAULT = 32;
    localparam int PUSH_WORD_W       = 32;
    localparam int POP_WORD_W        = 32;
    localparam int ENTRY_TOTAL_W     = 5;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

FILE: rtl/deq_store.sv
// Slot memory of the double-ended queue: one port, registered read data.
`timescale 1ns / 1ps

module deq_store
    import deq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int WORD_BITS = WORD_BITS_DEFAULT,
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                 clk,
    input  mem_ctl_t             mem_ctl,
    input  logic [IDX_W-1:0]     addr,
    input  logic [WORD_BITS-1:0] wdata,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    // Hold read data until the next pop reads.
    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (mem_ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/deq_ctrl.sv
// Pointer and fill-count control of the double-ended queue.
`timescale 1ns / 1ps

module deq_ctrl
    import deq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int WORD_BITS = WORD_BITS_DEFAULT,
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W    = $clog2(DEPTH + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [1:0]           mode,
    input  logic [WORD_BITS-1:0] word,
    output mem_ctl_t             mem_ctl,
    output logic [IDX_W-1:0]     mem_addr,
    output status_t              status_next,
    output logic [CNT_W-1:0]     count_next,
    output logic                 pop_ok,
    output logic [CNT_W-1:0]     fill
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [IDX_W-1:0] front_reg;
    logic [IDX_W-1:0] front_next;
    logic [IDX_W-1:0] back_reg;
    logic [IDX_W-1:0] back_next;
    logic [CNT_W-1:0] count_reg;

    logic [IDX_W-1:0] front_inc;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] back_inc;
    logic [IDX_W-1:0] back_dec;
    logic             is_full;
    logic             is_empty;
    logic             is_null;

    // Wrap the circular indexes at DEPTH.
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign back_inc  = (back_reg == LAST_IDX) ? '0 : back_reg + 1'b1;
    assign back_dec  = (back_reg == '0) ? LAST_IDX : back_reg - 1'b1;

    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);
    assign is_null  = (word == '0);

    always_comb
    begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        pop_ok      = 1'b0;
        mem_ctl     = '0;
        mem_addr    = front_reg;
        unique case (mode_t'(mode))
            MODE_PUSH_FRONT:
            begin
                if (is_null)
                begin
                    status_next = ST_INVALID;
                end
                else if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    mem_addr      = front_dec;
                    mem_ctl.wr_en = accept;
                    front_next    = front_dec;
                    count_next    = count_reg + 1'b1;
                end
            end
            MODE_PUSH_BACK:
            begin
                if (is_null)
                begin
                    status_next = ST_INVALID;
                end
                else if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    mem_addr      = back_reg;
                    mem_ctl.wr_en = accept;
                    back_next     = back_inc;
                    count_next    = count_reg + 1'b1;
                end
            end
            MODE_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    mem_addr      = front_reg;
                    mem_ctl.rd_en = accept;
                    pop_ok        = 1'b1;
                    front_next    = front_inc;
                    count_next    = count_reg - 1'b1;
                end
            end
            MODE_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    mem_addr      = back_dec;
                    mem_ctl.rd_en = accept;
                    pop_ok        = 1'b1;
                    back_next     = back_dec;
                    count_next    = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Advance pointers and count only on an accepted transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    assign fill = count_reg;

endmodule

FILE: rtl/double_ended_queue.sv
// Top level of the double-ended queue: request decode, slot memory, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  req     | in        | req_valid/req_stall  | mode, push_word
//  rsp     | out       | rsp_valid/rsp_stall  | status, pop_word, entry_total
//
// One request per cycle while req_stall is low; the result of each is shown in the
// cycle after its transfer. The slot memory has a single port: each request does at most
// one write (push) or one read (pop) at its transfer edge.
// rsp_stall holds the result register and raises req_stall while it is full.
// Reset (rst_n low, asynchronous) clears pointers, fill count and rsp_valid;
// the slot memory is not cleared, since a pop only reads slots a push wrote.
`timescale 1ns / 1ps
`include "double_ended_queue_defines.svh"

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int WORD_BITS = WORD_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic [1:0]               mode,
    input  logic [PUSH_WORD_W-1:0]   push_word,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic [1:0]               status,
    output logic [POP_WORD_W-1:0]    pop_word,
    output logic [ENTRY_TOTAL_W-1:0] entry_total
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                 accept;
    logic [WORD_BITS-1:0] word_in;
    mem_ctl_t             mem_ctl;
    logic [IDX_W-1:0]     mem_addr;
    logic [WORD_BITS-1:0] rdata;
    status_t              status_next;
    logic [CNT_W-1:0]     count_next;
    logic                 pop_ok;
    logic [CNT_W-1:0]     fill;

    logic                     rsp_valid_reg;
    status_t                  status_reg;
    logic [ENTRY_TOTAL_W-1:0] total_reg;
    logic                     pop_ok_reg;

    // Stall requests only while a result waits and the consumer stalls.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    // Keep the low WORD_BITS bits of the pushed word; zero means null.
    assign word_in = WORD_BITS'(push_word);

    deq_ctrl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .word        (word_in),
        .mem_ctl     (mem_ctl),
        .mem_addr    (mem_addr),
        .status_next (status_next),
        .count_next  (count_next),
        .pop_ok      (pop_ok),
        .fill        (fill)
    );

    deq_store #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_store (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .addr    (mem_addr),
        .wdata   (word_in),
        .rdata   (rdata)
    );

    // Drop the result flag once transferred out with nothing new behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Load the result fields alongside the memory read of the same request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            total_reg  <= ENTRY_TOTAL_W'(count_next);
            pop_ok_reg <= pop_ok;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign entry_total = total_reg;
    assign pop_word    = pop_ok_reg ? POP_WORD_W'(rdata) : '0;

    // A successful pop returns a word that a non-null push stored.
    `DEQ_ASSERT_SAME(a_pop_nonzero, clk, rst_n, rsp_valid_reg && pop_ok_reg, pop_word != '0)

    // A non-null push on a full queue reports full in the next result.
    `DEQ_ASSERT_NEXT(a_full_push, clk, rst_n, accept && (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_BACK) && word_in != '0 && fill == CNT_W'(DEPTH), status_reg == ST_FULL)

    // The fill count moves exactly when a request succeeds.
    `DEQ_ASSERT_NEXT(a_count_moves, clk, rst_n, accept, (status_reg == ST_OK) == (fill != $past(fill)))

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the double-ended queue: directed table, then random requests.
`timescale 1ns / 1ps

module testbench;
    import deq_pkg::*;

    localparam int QDEPTH         = DEPTH_DEFAULT;
    localparam int IDX_W          = $clog2(QDEPTH);
    localparam int RANDOM_ITEMS   = 950;
    localparam int PHASE_ITEMS    = 40;
    localparam int MAX_GAP        = 6;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int RESET_CYCLES   = 9;

    // One expected response: status, popped word, entries left after the request.
    typedef struct {
        status_t                  status;
        logic [POP_WORD_W-1:0]    word;
        logic [ENTRY_TOTAL_W-1:0] total;
    } deq_result_t;

    // One row of the directed table. When typed is set, want holds the result
    // written in by hand; otherwise the shadow queue supplies it.
    typedef struct {
        mode_t                 m;
        logic [PUSH_WORD_W-1:0] w;
        bit                    typed;
        deq_result_t           want;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    mode_t                    mode;
    logic [PUSH_WORD_W-1:0]   push_word;
    logic                     rsp_valid;
    logic                     rsp_stall;
    logic [1:0]               status;
    logic [POP_WORD_W-1:0]    pop_word;
    logic [ENTRY_TOTAL_W-1:0] entry_total;

    // Shadow copy of the queue contents and pointers.
    logic [PUSH_WORD_W-1:0]   shadow_slots [QDEPTH];
    logic [IDX_W-1:0]         shadow_head;
    logic [IDX_W-1:0]         shadow_tail;
    logic [ENTRY_TOTAL_W-1:0] shadow_fill;

    deq_result_t pending_results [$];
    stim_row_t   stim_table [$];
    int          mismatches;
    int          idle_cycles;
    bit          sender_quiet;
    bit          receiver_quiet;

    double_ended_queue u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .mode        (mode),
        .push_word   (push_word),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .pop_word    (pop_word),
        .entry_total (entry_total)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Apply one request to the shadow queue and return the response it must produce.
    // Head points at the front entry, tail one past the back entry; both wrap
    // naturally at the index width since the depth is a power of two.
    function automatic deq_result_t predict_request(input mode_t m,
                                                    input logic [PUSH_WORD_W-1:0] w);
        deq_result_t r;
        r.status = ST_OK;
        r.word   = '0;
        if (m == MODE_PUSH_FRONT || m == MODE_PUSH_BACK)
        begin
            // Null check wins over the full check.
            if (w == '0)
                r.status = ST_INVALID;
            else if (shadow_fill == ENTRY_TOTAL_W'(QDEPTH))
                r.status = ST_FULL;
            else if (m == MODE_PUSH_FRONT)
            begin
                shadow_head               = shadow_head - 1'b1;
                shadow_slots[shadow_head] = w;
                shadow_fill               = shadow_fill + 1'b1;
            end
            else
            begin
                shadow_slots[shadow_tail] = w;
                shadow_tail               = shadow_tail + 1'b1;
                shadow_fill               = shadow_fill + 1'b1;
            end
        end
        else if (shadow_fill == '0)
            r.status = ST_EMPTY;
        else if (m == MODE_POP_FRONT)
        begin
            r.word      = shadow_slots[shadow_head];
            shadow_head = shadow_head + 1'b1;
            shadow_fill = shadow_fill - 1'b1;
        end
        else
        begin
            shadow_tail = shadow_tail - 1'b1;
            r.word      = shadow_slots[shadow_tail];
            shadow_fill = shadow_fill - 1'b1;
        end
        r.total = shadow_fill;
        return r;
    endfunction

    task automatic add_row(input mode_t m, input logic [PUSH_WORD_W-1:0] w, input bit typed,
                           input status_t s, input logic [POP_WORD_W-1:0] pw,
                           input logic [ENTRY_TOTAL_W-1:0] t);
        stim_row_t row;
        row.m           = m;
        row.w           = w;
        row.typed       = typed;
        row.want.status = s;
        row.want.word   = pw;
        row.want.total  = t;
        stim_table.push_back(row);
    endtask

    // Drive one request from a falling edge, hold it until the transfer, and
    // return at the following falling edge. A gap drops valid first; with no
    // gap valid stays high, so each edge carries a single assignment to it.
    task automatic send_request(input mode_t m, input logic [PUSH_WORD_W-1:0] w,
                                input bit typed, input deq_result_t want);
        int          gap;
        deq_result_t got;
        gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode      <= m;
        push_word <= w;
        req_valid <= 1'b1;
        // Hold the payload while the block stalls.
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        got = predict_request(m, w);
        pending_results.push_back(typed ? want : got);
        @(negedge clk);
    endtask

    // Draw a random push word: mostly random, with nulls, all-ones and walking ones mixed in.
    function automatic logic [PUSH_WORD_W-1:0] draw_word();
        int pick;
        pick = $urandom_range(0, 19);
        case (pick)
            0:       return '0;
            1:       return '1;
            2:       return PUSH_WORD_W'(1) << $urandom_range(0, PUSH_WORD_W - 1);
            default: return $urandom;
        endcase
    endfunction

    // Stimulus: reset, directed table, random phases, then drain.
    initial
    begin
        int          i;
        int          k;
        bit          push_bias;
        bit          is_push;
        mode_t       m;
        deq_result_t none;

        rst_n          = 1'b0;
        req_valid      = 1'b0;
        mode           = MODE_PUSH_FRONT;
        push_word      = '0;
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
        mismatches     = 0;
        shadow_head    = '0;
        shadow_tail    = '0;
        shadow_fill    = '0;
        none.status    = ST_OK;
        none.word      = '0;
        none.total     = '0;

        // Pops on the empty queue; push_word must be ignored.
        add_row(MODE_POP_FRONT,  32'hFFFF_FFFF, 1'b1, ST_EMPTY,   '0, 5'd0);
        add_row(MODE_POP_BACK,   32'h0000_0001, 1'b1, ST_EMPTY,   '0, 5'd0);
        // Null pushes at both ends.
        add_row(MODE_PUSH_FRONT, 32'h0000_0000, 1'b1, ST_INVALID, '0, 5'd0);
        add_row(MODE_PUSH_BACK,  32'h0000_0000, 1'b1, ST_INVALID, '0, 5'd0);
        // Smallest and largest words.
        add_row(MODE_PUSH_BACK,  32'h0000_0001, 1'b1, ST_OK,      '0, 5'd1);
        add_row(MODE_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, ST_OK,      '0, 5'd2);
        // Fill to capacity from alternating ends.
        for (k = 2; k < QDEPTH; k++)
            add_row((k % 2) ? MODE_PUSH_FRONT : MODE_PUSH_BACK,
                    32'h5A00_0000 ^ (32'h1 << (k + 8)) ^ k, 1'b0, ST_OK, '0, '0);
        // Push on a full queue, then a null push on a full queue.
        add_row(MODE_PUSH_BACK,  32'h8000_0000, 1'b1, ST_FULL,    '0, 5'd16);
        add_row(MODE_PUSH_FRONT, 32'h0000_0000, 1'b1, ST_INVALID, '0, 5'd16);
        // Pops from a full queue with a nonzero word on the port.
        add_row(MODE_POP_FRONT,  32'hDEAD_BEEF, 1'b0, ST_OK,      '0, '0);
        add_row(MODE_POP_BACK,   32'hFFFF_FFFF, 1'b0, ST_OK,      '0, '0);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_table[j])
            send_request(stim_table[j].m, stim_table[j].w, stim_table[j].typed,
                         stim_table[j].want);

        // Random phases: each leans toward pushes or pops so the fill level
        // swings between empty and full; some phases run without idling.
        push_bias = 1'b1;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % PHASE_ITEMS == 0)
            begin
                push_bias      = $urandom_range(0, 1);
                sender_quiet   = ($urandom_range(0, 3) == 0);
                receiver_quiet = ($urandom_range(0, 3) == 0);
            end
            k       = $urandom_range(0, 99);
            is_push = push_bias ? (k < 75) : (k < 25);
            if (is_push)
                m = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
            else
                m = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
            send_request(m, is_push ? draw_word() : PUSH_WORD_W'($urandom), 1'b0, none);
        end
        req_valid <= 1'b0;

        // Drain outstanding responses, then watch for strays.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("double_ended_queue: match");
        else
            $display("double_ended_queue: mismatch");
        $finish;
    end

    // Response side: stall a random number of cycles per result, then take
    // the next transfer and compare it with the oldest expectation.
    initial
    begin
        int          hold;
        deq_result_t exp_r;

        rsp_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = receiver_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (rsp_valid !== 1'b1)
                @(posedge clk);
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d pop_word %h entry_total %0d",
                       status, pop_word, entry_total);
                mismatches++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_r.status, status);
                    mismatches++;
                end
                if (pop_word !== exp_r.word)
                begin
                    $error("pop_word: expected %h, actual %h", exp_r.word, pop_word);
                    mismatches++;
                end
                if (entry_total !== exp_r.total)
                begin
                    $error("entry_total: expected %0d, actual %0d", exp_r.total, entry_total);
                    mismatches++;
                end
            end
            @(negedge clk);
        end
    end

    // Watchdog: count cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((req_valid === 1'b1 && req_stall === 1'b0) ||
            (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("double_ended_queue: mismatch");
            $finish;
        end
    end

    initial
    begin
        idle_cycles = 0;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_store.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue.sv
verif/testbench.sv
